/* sv/rlz_pkg.sv */
// Shared constants and controller/datapath handshake types for the RefPack decompressor.
// No dependencies.
`default_nettype none
package rlz_pkg;

  localparam int unsigned WindowBytesDef = 131072;
  localparam int unsigned ChunkBytes     = 32;
  localparam int unsigned ChunkBits      = ChunkBytes * 8;
  localparam int unsigned CntW           = $clog2(ChunkBytes + 1);
  localparam logic [15:0] MagicReset     = 16'h10FB;
  localparam logic [0:0]  RegMagic       = 1'b0;

  typedef struct packed {
    logic accept;
    logic decode;
    logic rd;
    logic wr;
    logic endchk;
    logic load_chunk;
    logic load_stat;
    logic step_end;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic dec_copy;
    logic fin;
    logic copy_last;
    logic chunk_full;
    logic cnt_zero;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* sv/rlz_in_if.sv */
// Input channel: one compressed byte per word.
// Depends on nothing.
`default_nettype none
interface rlz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

/* sv/rlz_out_if.sv */
// Output channel: a chunk of up to 32 decoded bytes or a status word.
// Depends on nothing.
`default_nettype none
interface rlz_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes_a;
  logic [63:0] out_bytes_b;
  logic [63:0] out_bytes_c;
  logic [63:0] out_bytes_d;
  logic [5:0]  byte_count;
  logic        finished;
  logic [2:0]  status;

  modport source (output valid, output out_bytes_a, output out_bytes_b, output out_bytes_c,
                  output out_bytes_d, output byte_count, output finished, output status,
                  input ready);
  modport sink   (input valid, input out_bytes_a, input out_bytes_b, input out_bytes_c,
                  input out_bytes_d, input byte_count, input finished, input status,
                  output ready);
endinterface
`default_nettype wire

/* sv/refpack_lz_decompressor.sv */
// RefPack decompressor top level: one compressed byte per input word.
// Steps per input word: accept, decode, copy loop (registered history read, then write),
// end check, chunk flush, status word; no new word is accepted until back in idle. A chunk
// that fills mid-copy is sent before the copy goes on; a word's chunk precedes its status.
// Reset: async active low; parser returns to first header byte, magic to 0x10FB.
// History RAM needs no clearing; copies only read bytes written in the same stream.
`default_nettype none
module refpack_lz_decompressor #(
  parameter int unsigned WINDOW_BYTES = rlz_pkg::WindowBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rlz_in_if.sink           in_s,
  rlz_out_if.source        out_m,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [15:0]                   magic_q;
  rlz_pkg::cmd_t                 cmd;
  rlz_pkg::sts_t                 sts;
  logic [rlz_pkg::ChunkBits-1:0] chunk;

  assign pready = 1'b1;
  assign prdata = (paddr == {rlz_pkg::RegMagic, 2'b00}) ? {16'b0, magic_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= rlz_pkg::MagicReset;
    end else if (psel && penable && pwrite && paddr == {rlz_pkg::RegMagic, 2'b00}) begin
      magic_q <= pwdata[15:0];
    end
  end

  rlz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_ready_o (in_s.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rlz_datapath #(
    .WindowBytes (WINDOW_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .magic_i     (magic_q),
    .in_byte_i   (in_s.in_byte),
    .in_last_i   (in_s.in_last),
    .out_ready_i (out_m.ready),
    .out_valid_o (out_m.valid),
    .out_chunk_o (chunk),
    .out_count_o (out_m.byte_count),
    .out_fin_o   (out_m.finished),
    .out_stat_o  (out_m.status)
  );

  assign out_m.out_bytes_a = chunk[63:0];
  assign out_m.out_bytes_b = chunk[127:64];
  assign out_m.out_bytes_c = chunk[191:128];
  assign out_m.out_bytes_d = chunk[255:192];

endmodule
`default_nettype wire

/* sv/rlz_ram.sv */
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none
module rlz_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 131072
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* sv/rlz_datapath.sv */
// Stream parser, history memory, chunk packer and output register.
// Depends on rlz_pkg and rlz_ram.
`default_nettype none
module rlz_datapath #(
  parameter int unsigned WindowBytes = rlz_pkg::WindowBytesDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rlz_pkg::cmd_t              cmd_i,
  output rlz_pkg::sts_t                   sts_o,
  input  wire logic [15:0]                magic_i,
  input  wire logic [7:0]                 in_byte_i,
  input  wire logic                       in_last_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic [rlz_pkg::ChunkBits-1:0]   out_chunk_o,
  output logic [5:0]                      out_count_o,
  output logic                            out_fin_o,
  output logic [2:0]                      out_stat_o
);

  localparam int unsigned AddrW = $clog2(WindowBytes);

  localparam logic [2:0] PH_HDR   = 3'd0;
  localparam logic [2:0] PH_SKIP  = 3'd1;
  localparam logic [2:0] PH_CMD   = 3'd2;
  localparam logic [2:0] PH_C2    = 3'd3;
  localparam logic [2:0] PH_C3    = 3'd4;
  localparam logic [2:0] PH_C4    = 3'd5;
  localparam logic [2:0] PH_LIT   = 3'd6;
  localparam logic [2:0] PH_LSKIP = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_MAGIC    = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_OVERRUN  = 3'd4;
  localparam logic [2:0] ST_OFFSET   = 3'd5;
  localparam logic [2:0] ST_MISMATCH = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  hcnt_q, hcnt_d;
  logic [23:0] exp_q, exp_d;
  logic [23:0] pos_q, pos_d;
  logic [7:0]  c1_q, c1_d, c2_q, c2_d, c3_q, c3_d;
  logic [7:0]  lit_q, lit_d;
  logic [17:0] poff_q, poff_d;
  logic [10:0] plen_q, plen_d;
  logic        done_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        fin_q;
  logic [2:0]  stat_q;

  logic [rlz_pkg::ChunkBits-1:0] chunk_q;
  logic [rlz_pkg::CntW-1:0]      cnt_q;

  logic        dec_emit, dec_fin, dec_copy;
  logic [2:0]  dec_stat, end_stat;
  logic        do_cpy, do_lit, do_after;
  logic [7:0]  lit_v, c4_v;
  logic [15:0] magic_v;

  logic             ram_we;
  logic [7:0]       ram_wdata, ram_rdata;
  logic [23:0]      src_pos;
  logic             app_en;

  always_comb begin
    phase_d  = phase_q;
    hcnt_d   = hcnt_q;
    exp_d    = exp_q;
    pos_d    = pos_q;
    c1_d     = c1_q;
    c2_d     = c2_q;
    c3_d     = c3_q;
    lit_d    = lit_q;
    poff_d   = poff_q;
    plen_d   = plen_q;
    dec_emit = 1'b0;
    dec_fin  = 1'b0;
    dec_stat = ST_OK;
    dec_copy = 1'b0;
    do_cpy   = 1'b0;
    do_lit   = 1'b0;
    do_after = 1'b0;
    lit_v    = '0;
    c4_v     = '0;
    magic_v  = '0;
    case (phase_q)
      PH_HDR: begin
        if (hcnt_q == 4'd0) begin
          c1_d = byte_q;
        end else if (hcnt_q == 4'd1) begin
          c2_d = byte_q;
        end else begin
          exp_d = {exp_q[15:0], byte_q};
        end
        hcnt_d = hcnt_q + 4'd1;
        if (hcnt_d >= 4'd5) begin
          magic_v = {c1_d[7:1], 1'b0, c2_d};
          if (magic_v != magic_i) begin
            dec_fin  = 1'b1;
            dec_stat = ST_MAGIC;
          end else if (exp_d == 24'd0) begin
            dec_fin  = 1'b1;
            dec_stat = ST_OK;
          end else begin
            phase_d = c1_d[0] ? PH_SKIP : PH_CMD;
          end
        end
      end
      PH_SKIP: begin
        hcnt_d = hcnt_q + 4'd1;
        if (hcnt_d >= 4'd8) begin
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        c1_d = byte_q;
        if (byte_q <= 8'hDF) begin
          phase_d = PH_C2;
        end else if (byte_q <= 8'hFB) begin
          do_lit = 1'b1;
          lit_v  = {1'b0, byte_q[4:0], 2'b00} + 8'd4;
        end else begin
          do_lit = 1'b1;
          lit_v  = {6'b0, byte_q[1:0]};
        end
      end
      PH_C2: begin
        c2_d = byte_q;
        if (c1_q <= 8'h7F) begin
          do_cpy = 1'b1;
        end else begin
          phase_d = PH_C3;
        end
      end
      PH_C3: begin
        c3_d = byte_q;
        if (c1_q <= 8'hBF) begin
          do_cpy = 1'b1;
        end else begin
          phase_d = PH_C4;
        end
      end
      PH_C4: begin
        do_cpy = 1'b1;
        c4_v   = byte_q;
      end
      PH_LIT: begin
        dec_emit = 1'b1;
        pos_d    = pos_q + 24'd1;
        lit_d    = lit_q - 8'd1;
        if (lit_d == 8'd0) begin
          do_after = 1'b1;
        end
      end
      PH_LSKIP: begin
        lit_d = lit_q - 8'd1;
        if (lit_d == 8'd0) begin
          dec_fin  = 1'b1;
          dec_stat = ST_OVERRUN;
        end
      end
      default: begin
        phase_d = PH_CMD;
      end
    endcase

    if (do_cpy) begin
      do_lit = 1'b1;
      if (c1_q <= 8'h7F) begin
        poff_d = {8'b0, c1_q[6:5], c2_d} + 18'd1;
        plen_d = {8'b0, c1_q[4:2]} + 11'd3;
        lit_v  = {6'b0, c1_q[1:0]};
      end else if (c1_q <= 8'hBF) begin
        poff_d = {4'b0, c2_d[5:0], c3_d} + 18'd1;
        plen_d = {5'b0, c1_q[5:0]} + 11'd4;
        lit_v  = {6'b0, c2_d[7:6]};
      end else begin
        poff_d = {1'b0, c1_q[4], c2_d, c3_d} + 18'd1;
        plen_d = {1'b0, c1_q[3:2], c4_v} + 11'd5;
        lit_v  = {6'b0, c1_q[1:0]};
      end
    end

    if (do_lit) begin
      if (lit_v == 8'd0) begin
        do_after = 1'b1;
      end else begin
        lit_d   = lit_v;
        phase_d = (({1'b0, pos_q} + {17'b0, lit_v}) > {1'b0, exp_q}) ? PH_LSKIP : PH_LIT;
      end
    end

    if (do_after) begin
      if (c1_d <= 8'hDF) begin
        if (({1'b0, pos_d} + {14'b0, plen_d}) > {1'b0, exp_d}) begin
          dec_fin  = 1'b1;
          dec_stat = ST_OVERRUN;
        end else if (poff_d == 18'd0 || {6'b0, poff_d} > pos_d) begin
          dec_fin  = 1'b1;
          dec_stat = ST_OFFSET;
        end else begin
          dec_copy = 1'b1;
          phase_d  = PH_CMD;
        end
      end else if (c1_d >= 8'hFC) begin
        dec_fin  = 1'b1;
        dec_stat = (pos_d == exp_d) ? ST_OK : ST_MISMATCH;
      end else begin
        phase_d = PH_CMD;
      end
    end
  end

  always_comb begin
    if (phase_q == PH_HDR) begin
      end_stat = ST_SHORT;
    end else if (phase_q == PH_SKIP || phase_q == PH_CMD) begin
      end_stat = (pos_q == exp_q) ? ST_OK : ST_MISMATCH;
    end else begin
      end_stat = ST_TRUNC;
    end
  end

  assign src_pos   = pos_q - {6'b0, poff_q};
  assign ram_we    = (cmd_i.decode && dec_emit) || cmd_i.wr;
  assign ram_wdata = cmd_i.wr ? ram_rdata : byte_q;
  assign app_en    = ram_we;

  rlz_ram #(
    .Width (8),
    .Depth (WindowBytes)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (src_pos[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      hcnt_q  <= '0;
      exp_q   <= '0;
      pos_q   <= '0;
      c1_q    <= '0;
      c2_q    <= '0;
      c3_q    <= '0;
      lit_q   <= '0;
      poff_q  <= '0;
      plen_q  <= '0;
      done_q  <= 1'b0;
      fin_q   <= 1'b0;
      stat_q  <= ST_OK;
      last_q  <= 1'b0;
      cnt_q   <= '0;
      chunk_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        last_q <= in_last_i;
      end
      if (cmd_i.decode) begin
        phase_q <= phase_d;
        hcnt_q  <= hcnt_d;
        exp_q   <= exp_d;
        pos_q   <= pos_d;
        c1_q    <= c1_d;
        c2_q    <= c2_d;
        c3_q    <= c3_d;
        lit_q   <= lit_d;
        poff_q  <= poff_d;
        plen_q  <= plen_d;
        fin_q   <= dec_fin;
        stat_q  <= dec_stat;
      end
      if (cmd_i.wr) begin
        pos_q  <= pos_q + 24'd1;
        plen_q <= plen_q - 11'd1;
      end
      if (cmd_i.endchk && !fin_q && last_q) begin
        fin_q  <= 1'b1;
        stat_q <= end_stat;
      end
      if (cmd_i.load_chunk) begin
        cnt_q   <= '0;
        chunk_q <= '0;
      end else if (app_en) begin
        cnt_q <= cnt_q + 1'b1;
        chunk_q[cnt_q[rlz_pkg::CntW-2:0]*8 +: 8] <= ram_wdata;
      end
      if (cmd_i.step_end) begin
        if (last_q) begin
          phase_q <= PH_HDR;
          hcnt_q  <= '0;
          exp_q   <= '0;
          pos_q   <= '0;
          c1_q    <= '0;
          c2_q    <= '0;
          c3_q    <= '0;
          lit_q   <= '0;
          poff_q  <= '0;
          plen_q  <= '0;
          done_q  <= 1'b0;
        end else if (fin_q) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= in_byte_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_chunk || cmd_i.load_stat) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_chunk) begin
      out_chunk_o <= chunk_q;
      out_count_o <= 6'(cnt_q);
      out_fin_o   <= 1'b0;
      out_stat_o  <= ST_OK;
    end else if (cmd_i.load_stat) begin
      out_chunk_o <= '0;
      out_count_o <= '0;
      out_fin_o   <= 1'b1;
      out_stat_o  <= stat_q;
    end
  end

  assign sts_o.done       = done_q;
  assign sts_o.dec_copy   = dec_copy;
  assign sts_o.fin        = fin_q;
  assign sts_o.copy_last  = (plen_q == 11'd1);
  assign sts_o.chunk_full = (cnt_q == rlz_pkg::CntW'(rlz_pkg::ChunkBytes - 1));
  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign sts_o.out_free   = !out_valid_o || out_ready_i;

endmodule
`default_nettype wire

/* sv/rlz_ctrl.sv */
// Sequencer: accept, decode, history copy loop, chunk flush and status word.
// Depends on rlz_pkg.
`default_nettype none
module rlz_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rlz_pkg::sts_t sts_i,
  output rlz_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_CRD   = 3'd2;
  localparam logic [2:0] S_CWR   = 3'd3;
  localparam logic [2:0] S_FMID  = 3'd4;
  localparam logic [2:0] S_ENDC  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;
  localparam logic [2:0] S_STAT  = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.accept = in_valid_i && in_ready_o;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.accept) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.done) begin
          cmd_o.step_end = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.decode = 1'b1;
          state_d      = sts_i.dec_copy ? S_CRD : S_ENDC;
        end
      end
      S_CRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CWR;
      end
      S_CWR: begin
        cmd_o.wr = 1'b1;
        if (sts_i.copy_last) begin
          state_d = S_ENDC;
        end else if (sts_i.chunk_full) begin
          state_d = S_FMID;
        end else begin
          state_d = S_CRD;
        end
      end
      S_FMID: begin
        if (sts_i.out_free) begin
          cmd_o.load_chunk = 1'b1;
          state_d          = S_CRD;
        end
      end
      S_ENDC: begin
        cmd_o.endchk = 1'b1;
        state_d      = S_FLUSH;
      end
      S_FLUSH: begin
        if (sts_i.cnt_zero) begin
          state_d = S_STAT;
        end else if (sts_i.out_free) begin
          cmd_o.load_chunk = 1'b1;
          state_d          = S_STAT;
        end
      end
      S_STAT: begin
        if (!sts_i.fin) begin
          cmd_o.step_end = 1'b1;
          state_d        = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.load_stat = 1'b1;
          cmd_o.step_end  = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_chunk || cmd_o.load_stat) |-> sts_i.out_free)
    else $error("output register overwritten");
  a_rd_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRD) |=> (state_q == S_CWR))
    else $error("copy read not followed by write");
  a_copy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CWR && sts_i.copy_last) |=> (state_q == S_ENDC))
    else $error("copy overran its length");
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load_chunk && cmd_o.load_stat))
    else $error("chunk and status loaded together");

endmodule
`default_nettype wire

/* test/tb.sv */
// Testbench for refpack_lz_decompressor: drives compressed streams through the byte channel
// and checks every chunk and status word against an in-bench decoder model.
// Depends on rlz_pkg, rlz_in_if, rlz_out_if and the RTL top level.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Window = rlz_pkg::WindowBytesDef;
  localparam int unsigned WatchLimit = 200000;

  typedef enum logic [3:0] {
    PhHdr, PhSkip, PhCmd, PhC2, PhC3, PhC4, PhLit, PhLskip
  } phase_e;

  typedef enum logic [2:0] {
    StOk, StShort, StMagic, StTrunc, StOverrun, StOffset, StSize
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [255:0] bytes;
    logic [5:0]   cnt;
    logic         fin;
    logic [2:0]   st;
  } out_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rlz_in_if in_ch ();
  rlz_out_if out_ch ();

  refpack_lz_decompressor u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_s(in_ch.sink), .out_m(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk_i = ~clk_i;

  // decoder model state
  logic [15:0] mdl_magic;
  phase_e      mdl_phase;
  int unsigned mdl_hcnt, mdl_size, mdl_pos, mdl_c1, mdl_c2, mdl_c3, mdl_lit_left;
  int unsigned mdl_off, mdl_len;
  bit          mdl_done, mdl_fin;
  logic [2:0]  mdl_st;
  logic [7:0]  mdl_hist [Window];
  logic [7:0]  step_bytes [$];

  in_word_t  byte_queue [$];
  out_word_t expected_words [$];
  int unsigned errors = 0, n_in = 0, n_out = 0, n_status = 0;
  int unsigned src_idle = 0, snk_stall = 0;

  function automatic void restart_decoder();
    mdl_phase = PhHdr; mdl_hcnt = 0; mdl_size = 0; mdl_pos = 0;
    mdl_c1 = 0; mdl_c2 = 0; mdl_c3 = 0; mdl_lit_left = 0;
    mdl_off = 0; mdl_len = 0; mdl_done = 0;
  endfunction

  function automatic void end_with(status_e s);
    mdl_fin = 1; mdl_st = s;
  endfunction

  function automatic void emit_out(logic [7:0] b);
    mdl_hist[mdl_pos % Window] = b;
    mdl_pos = (mdl_pos + 1) & 24'hFFFFFF;
    step_bytes.push_back(b);
  endfunction

  function automatic void after_literals();
    if (mdl_c1 <= 8'hDF) begin
      if (mdl_pos + mdl_len > mdl_size) end_with(StOverrun);
      else if (mdl_off == 0 || mdl_off > mdl_pos) end_with(StOffset);
      else begin
        for (int unsigned i = 0; i < mdl_len; i++)
          emit_out(mdl_hist[(mdl_pos - mdl_off) % Window]);
        mdl_phase = PhCmd;
      end
    end else if (mdl_c1 >= 8'hFC) begin
      end_with(mdl_pos == mdl_size ? StOk : StSize);
    end else begin
      mdl_phase = PhCmd;
    end
  endfunction

  function automatic void begin_literals(int unsigned n);
    if (n == 0) begin
      after_literals();
      return;
    end
    mdl_lit_left = n;
    mdl_phase = (mdl_pos + n > mdl_size) ? PhLskip : PhLit;
  endfunction

  function automatic void decode_copy(int unsigned c4);
    if (mdl_c1 <= 8'h7F) begin
      mdl_off = ((mdl_c1 & 8'h60) << 3) + mdl_c2 + 1;
      mdl_len = ((mdl_c1 & 8'h1C) >> 2) + 3;
      begin_literals(mdl_c1 & 3);
    end else if (mdl_c1 <= 8'hBF) begin
      mdl_off = ((mdl_c2 & 8'h3F) << 8) + mdl_c3 + 1;
      mdl_len = (mdl_c1 & 8'h3F) + 4;
      begin_literals((mdl_c2 >> 6) & 3);
    end else begin
      mdl_off = ((mdl_c1 & 8'h10) << 12) + (mdl_c2 << 8) + mdl_c3 + 1;
      mdl_len = ((mdl_c1 & 8'h0C) << 6) + c4 + 5;
      begin_literals(mdl_c1 & 3);
    end
  endfunction

  function automatic void parse_byte(int unsigned b);
    case (mdl_phase)
      PhHdr: begin
        if (mdl_hcnt == 0) mdl_c1 = b;
        else if (mdl_hcnt == 1) mdl_c2 = b;
        else mdl_size = ((mdl_size << 8) | b) & 24'hFFFFFF;
        mdl_hcnt++;
        if (mdl_hcnt >= 5) begin
          if ((((mdl_c1 & 8'hFE) << 8) | mdl_c2) != mdl_magic) end_with(StMagic);
          else if (mdl_size == 0) end_with(StOk);
          else mdl_phase = (mdl_c1 & 1) ? PhSkip : PhCmd;
        end
      end
      PhSkip: begin
        mdl_hcnt++;
        if (mdl_hcnt >= 8) mdl_phase = PhCmd;
      end
      PhCmd: begin
        mdl_c1 = b;
        if (b <= 8'hDF) mdl_phase = PhC2;
        else if (b <= 8'hFB) begin_literals(((b & 8'h1F) << 2) + 4);
        else begin_literals(b & 3);
      end
      PhC2: begin
        mdl_c2 = b;
        if (mdl_c1 <= 8'h7F) decode_copy(0);
        else mdl_phase = PhC3;
      end
      PhC3: begin
        mdl_c3 = b;
        if (mdl_c1 <= 8'hBF) decode_copy(0);
        else mdl_phase = PhC4;
      end
      PhC4: decode_copy(b);
      PhLit: begin
        emit_out(b[7:0]);
        mdl_lit_left--;
        if (mdl_lit_left == 0) after_literals();
      end
      PhLskip: begin
        mdl_lit_left--;
        if (mdl_lit_left == 0) end_with(StOverrun);
      end
      default: mdl_phase = PhCmd;
    endcase
  endfunction

  function automatic void predict_words(in_word_t w);
    out_word_t o;
    int unsigned k;
    if (mdl_done) begin
      if (w.last) restart_decoder();
      return;
    end
    step_bytes.delete();
    mdl_fin = 0; mdl_st = StOk;
    parse_byte(w.data);
    if (!mdl_fin && w.last) begin
      if (mdl_phase == PhHdr) end_with(StShort);
      else if (mdl_phase == PhSkip || mdl_phase == PhCmd)
        end_with(mdl_pos == mdl_size ? StOk : StSize);
      else end_with(StTrunc);
    end
    k = 0;
    while (k < step_bytes.size()) begin
      o = '0;
      for (int unsigned i = 0; i < 32 && k < step_bytes.size(); i++) begin
        o.bytes[i*8 +: 8] = step_bytes[k];
        o.cnt++;
        k++;
      end
      expected_words.push_back(o);
    end
    if (mdl_fin) begin
      o = '0; o.fin = 1; o.st = mdl_st;
      expected_words.push_back(o);
    end
    if (w.last) restart_decoder();
    else if (mdl_fin) mdl_done = 1;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.in_byte <= '0;
      in_ch.in_last <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        predict_words('{data: in_ch.in_byte, last: in_ch.in_last});
        n_in++;
      end
      if (byte_queue.size() > 0 && $urandom_range(99) >= src_idle) begin
        in_ch.valid <= 1'b1;
        {in_ch.in_byte, in_ch.in_last} <= byte_queue.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_out++;
        if (expected_words.size() == 0) begin
          $error("unexpected output word");
          errors++;
        end else begin
          out_word_t e;
          e = expected_words.pop_front();
          if (out_ch.finished) n_status++;
          if ({out_ch.out_bytes_d, out_ch.out_bytes_c, out_ch.out_bytes_b,
               out_ch.out_bytes_a} !== e.bytes) begin
            $error("out_bytes exp %h got %h", e.bytes, {out_ch.out_bytes_d,
                   out_ch.out_bytes_c, out_ch.out_bytes_b, out_ch.out_bytes_a});
            errors++;
          end
          if (out_ch.byte_count !== e.cnt) begin
            $error("byte_count exp %0d got %0d", e.cnt, out_ch.byte_count);
            errors++;
          end
          if (out_ch.finished !== e.fin) begin
            $error("finished exp %0d got %0d", e.fin, out_ch.finished);
            errors++;
          end
          if (out_ch.status !== e.st) begin
            $error("status exp %0d got %0d", e.st, out_ch.status);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  // watchdog
  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic write_magic(logic [15:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {rlz_pkg::RegMagic, 2'b00}; pwdata <= {16'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mdl_magic = v;
  endtask

  task automatic push(logic [7:0] b, bit last = 0);
    byte_queue.push_back('{data: b, last: last});
  endtask

  task automatic push_header(bit ext, int unsigned size);
    push({mdl_magic[15:9], mdl_magic[8] | ext});
    push(mdl_magic[7:0]);
    push(size[23:16]); push(size[15:8]); push(size[7:0]);
    if (ext) begin
      push(8'($urandom)); push(8'($urandom)); push(8'($urandom));
    end
  endtask

  // Well-formed stream with random content; occasional corruption
  task automatic random_stream();
    int unsigned pos, size, kind, lit, len, off, c;
    bit ext;
    logic [7:0] cmd [$];
    pos = 0;
    cmd.delete();
    // build commands first to know the size
    repeat ($urandom_range(1, 5)) begin
      kind = $urandom_range(4);
      lit = $urandom_range(3);
      if (kind == 3 || pos == 0) begin
        lit = $urandom_range(0, 3) * 4 + 4;
        cmd.push_back(8'(8'hE0 | ((lit - 4) >> 2)));
        repeat (lit) cmd.push_back(8'($urandom));
        pos += lit;
      end else if (kind == 0 || kind == 4) begin
        len = $urandom_range(3, 10);
        off = $urandom_range(1, (pos + lit) < 1024 ? pos + lit : 1024);
        off -= 1;
        cmd.push_back({1'b0, off[9:8], len[2:0] - 3'd3, lit[1:0]});
        cmd.push_back(off[7:0]);
        repeat (lit) cmd.push_back(8'($urandom));
        pos += lit + len;
      end else if (kind == 1) begin
        len = $urandom_range(4, 67);
        off = $urandom_range(1, pos + lit) - 1;
        cmd.push_back({2'b10, len[5:0] - 6'd4});
        cmd.push_back({lit[1:0], off[13:8]});
        cmd.push_back(off[7:0]);
        repeat (lit) cmd.push_back(8'($urandom));
        pos += lit + len;
      end else begin
        len = $urandom_range(5, 80);
        off = $urandom_range(1, pos + lit) - 1;
        c = len - 5;
        cmd.push_back({3'b110, off[16], c[9:8], lit[1:0]});
        cmd.push_back(off[15:8]);
        cmd.push_back(off[7:0]);
        cmd.push_back(c[7:0]);
        repeat (lit) cmd.push_back(8'($urandom));
        pos += lit + len;
      end
    end
    lit = $urandom_range(3);
    cmd.push_back(8'(8'hFC | lit));
    repeat (lit) cmd.push_back(8'($urandom));
    pos += lit;
    size = pos;
    ext = 1'($urandom_range(1));
    c = $urandom_range(9);
    if (c == 0) size = pos - $urandom_range(1, 3);
    else if (c == 1) size = pos + 1;
    push_header(ext, size);
    if (c == 2) begin
      c = $urandom_range(1, cmd.size() - 1);
      cmd = cmd[0:c-1];
    end else if (c == 3) begin
      cmd[$urandom_range(cmd.size() - 1)] = 8'($urandom);
    end
    foreach (cmd[i]) push(cmd[i], i == cmd.size() - 1);
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    while ((byte_queue.size() > 0 || in_ch.valid || expected_words.size() > 0)
           && guard < 500000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.in_byte = '0; in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    mdl_magic = rlz_pkg::MagicReset;
    restart_decoder();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: short stream, bad magic, zero size, literals, copies, faults
    push(8'h10); push(8'hFB, 1);
    push(8'h00); push(8'h00); push(8'h00); push(8'h00); push(8'h05);
    push(8'hFF); push(8'h00, 1);
    push_header(0, 0); push(8'h55, 1);
    push_header(1, 9);
    push(8'hE0); push(8'h00); push(8'hFF); push(8'hA5); push(8'h5A);
    push(8'h00 | (3'd2 << 2) | 2'd1); push(8'h03); push(8'h7E);
    push(8'hFC, 1);
    push_header(0, 4); push(8'hE1); push(8'h11); push(8'h22, 1);
    push_header(0, 8); push(8'hE0); push(8'h01); push(8'h02); push(8'h03); push(8'h04);
    push(8'h04); push(8'h09); push(8'hFF, 1);
    push_header(0, 4); push(8'hE0); push(8'h01); push(8'h02); push(8'h03); push(8'h04);
    push(8'h08); push(8'h00); push(8'hFD); push(8'h01, 1);
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_magic(16'h0000); src_idle = 0;  snk_stall = 0;  end
        1: begin write_magic(16'hFFFE); src_idle = 64; snk_stall = 0;  end
        2: begin write_magic(16'h10FB); src_idle = 0;  snk_stall = 64; end
        3: begin write_magic(16'($urandom) & 16'hFEFF); src_idle = 7; snk_stall = 7; end
        default: begin write_magic(16'h10FB); src_idle = 0; snk_stall = 0; end
      endcase
      while (byte_queue.size() < 24) begin
        if ($urandom_range(9) == 0) push(8'($urandom), $urandom_range(3) == 0);
        else random_stream();
      end
      wait_drained();
    end
    $display("fed %0d bytes, checked %0d output words (%0d status) over 5 magic settings",
             n_in, n_out, n_status);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
sv/rlz_pkg.sv
sv/rlz_in_if.sv
sv/rlz_out_if.sv
sv/rlz_ram.sv
sv/rlz_datapath.sv
sv/rlz_ctrl.sv
sv/refpack_lz_decompressor.sv
test/tb.sv
